@@ rtl/assert_macros.svh @@
// assertion macros shared by the divider, datapath and controller rtl files
// expects clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/dvpb_pkg.sv @@
// types and constants for the delayed vibrato pitch bend block
// used by the interfaces, divider, datapath, controller and top level
package dvpb_pkg;

    localparam int unsigned FREQ_W  = 24;
    localparam int unsigned RATE_W  = 16;
    localparam int unsigned DEPTH_W = 15;
    localparam int unsigned SPAN_W  = 20;
    localparam int unsigned SR_W    = 18;
    localparam int unsigned AGE_W   = 22;

    localparam int unsigned DIV_NUM_W = 48;
    localparam int unsigned DIV_DEN_W = 20;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_NUM_W);

    localparam logic [SR_W-1:0]   SR_RESET  = 18'd48000;
    localparam logic [13:0]       DEPTH_MAX = 14'd12000;
    localparam logic [16:0]       Q16_ONE   = 17'd65536;
    localparam logic [16:0]       SIN_A     = 17'd102944;
    localparam logic [16:0]       SIN_B     = 17'd42048;
    localparam logic [16:0]       SIN_C     = 17'd4640;
    localparam logic [16:0]       EXP_C1    = 17'd45426;
    localparam logic [16:0]       EXP_C2    = 17'd14904;
    localparam logic [16:0]       EXP_C3    = 17'd5206;
    // x / 1200 as ((x >> 4) * ceil(2^33 / 75)) >> 33, exact for x below 2^30
    localparam logic [26:0]       RECIP_75  = 27'd114532462;
    localparam logic [FREQ_W-1:0] OUT_MAX   = 24'hFFFFFF;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_GSET,
        OP_GTAKE,
        OP_S1,
        OP_S2,
        OP_S3,
        OP_S4,
        OP_M1,
        OP_M2,
        OP_M3,
        OP_ETAKE,
        OP_X1,
        OP_X2,
        OP_X3,
        OP_X4,
        OP_PTAKE,
        OP_OUT
    } dvpb_op_t;

    typedef enum logic [1:0] {
        DSEL_GROWN,
        DSEL_PHASE
    } dvpb_dsel_t;

    typedef struct packed {
        dvpb_op_t   op;
        logic       div_start;
        dvpb_dsel_t div_sel;
    } dvpb_cmd_t;

    typedef struct packed {
        logic need_div;
        logic phase_go;
        logic div_done;
        logic out_busy;
    } dvpb_stat_t;

endpackage

@@ rtl/dvpb_ifs.sv @@
// valid/ready channel interfaces: input items, result items, config writes
// depends on dvpb_pkg for field widths
interface dvpb_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  voice_start;
    logic [dvpb_pkg::FREQ_W-1:0]           in_freq;
    logic signed [dvpb_pkg::RATE_W-1:0]    lfo_rate;
    logic signed [dvpb_pkg::DEPTH_W-1:0]   depth_cents;
    logic [dvpb_pkg::SPAN_W-1:0]           hold_samples;
    logic [dvpb_pkg::SPAN_W-1:0]           rise_samples;
    modport source (output valid, voice_start, in_freq, lfo_rate, depth_cents,
                    hold_samples, rise_samples, input ready);
    modport sink (input valid, voice_start, in_freq, lfo_rate, depth_cents,
                  hold_samples, rise_samples, output ready);
endinterface

interface dvpb_out_if;
    logic                          valid;
    logic                          ready;
    logic [dvpb_pkg::FREQ_W-1:0]   out_freq;
    logic                          saturated;
    modport source (output valid, out_freq, saturated, input ready);
    modport sink (input valid, out_freq, saturated, output ready);
endinterface

interface dvpb_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [dvpb_pkg::SR_W-1:0]   sample_rate;
    modport source (output valid, sample_rate, input ready);
    modport sink (input valid, sample_rate, output ready);
endinterface

@@ rtl/delayed_vibrato_pitch_bend_top.sv @@
// one item at a time: no new item is taken until the result of the last one is loaded;
// the rise ramp and the lfo phase step each add a division when they need one
// each division is a 48-step serial divide; the next item can be taken in the cycle
// after the result is loaded
// the result waits in an output register; only an unread one stalls the next
// rst_n clears phase, voice age and the output beat, and sets sample_rate to 48000
module delayed_vibrato_pitch_bend_top #(
    parameter int unsigned SPAN_BITS  = 20,
    parameter int unsigned PHASE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    dvpb_in_if.sink     in_ch,
    dvpb_out_if.source  out_ch,
    dvpb_cfg_if.sink    cfg_ch
);
    import dvpb_pkg::*;

    dvpb_cmd_t  cmd;
    dvpb_stat_t stat;
    logic       in_ready;

    assign in_ch.ready = in_ready;

    dvpb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dvpb_datapath #(
        .SPAN_BITS  (SPAN_BITS),
        .PHASE_BITS (PHASE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .voice_start  (in_ch.voice_start),
        .in_freq      (in_ch.in_freq),
        .lfo_rate     (in_ch.lfo_rate),
        .depth_cents  (in_ch.depth_cents),
        .hold_samples (in_ch.hold_samples),
        .rise_samples (in_ch.rise_samples),
        .cfg_ch       (cfg_ch),
        .out_ch       (out_ch)
    );

endmodule

@@ rtl/dvpb_div.sv @@
// serial restoring divider, one quotient bit per cycle
// depends on dvpb_pkg and assert_macros.svh
`include "assert_macros.svh"
module dvpb_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [dvpb_pkg::DIV_NUM_W-1:0]     num,
    input  logic [dvpb_pkg::DIV_DEN_W-1:0]     den,
    output logic                               done,
    output logic [dvpb_pkg::DIV_NUM_W-1:0]     quot
);
    import dvpb_pkg::*;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0]   num_reg, num_next;
    logic [DIV_DEN_W-1:0]   rem_reg, rem_next;
    logic [DIV_DEN_W-1:0]   den_reg, den_next;
    logic [DIV_DEN_W:0]     shifted;
    logic                   qbit;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        shifted   = {rem_reg, num_reg[DIV_NUM_W-1]};
        qbit      = (shifted >= {1'b0, den_reg});
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_NUM_W - 1);
            num_next  = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? DIV_DEN_W'(shifted - {1'b0, den_reg})
                            : shifted[DIV_DEN_W-1:0];
            num_next = {num_reg[DIV_NUM_W-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = num_reg;

    `ASSERT_IMPL(a_start_idle, start, !busy_reg)
    `ASSERT_NEXT(a_done_once, done_reg, !done_reg)

endmodule

@@ rtl/dvpb_datapath.sv @@
// datapath: operand registers, shared multiplier, divider, output register
// depends on dvpb_pkg, dvpb_ifs, dvpb_div and assert_macros.svh
`include "assert_macros.svh"
module dvpb_datapath #(
    parameter int unsigned SPAN_BITS  = 20,
    parameter int unsigned PHASE_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dvpb_pkg::dvpb_cmd_t                  cmd,
    output dvpb_pkg::dvpb_stat_t                 stat,
    input  logic                                 voice_start,
    input  logic [dvpb_pkg::FREQ_W-1:0]          in_freq,
    input  logic signed [dvpb_pkg::RATE_W-1:0]   lfo_rate,
    input  logic signed [dvpb_pkg::DEPTH_W-1:0]  depth_cents,
    input  logic [dvpb_pkg::SPAN_W-1:0]          hold_samples,
    input  logic [dvpb_pkg::SPAN_W-1:0]          rise_samples,
    dvpb_cfg_if.sink                             cfg_ch,
    dvpb_out_if.source                           out_ch
);
    import dvpb_pkg::*;

    localparam logic [SPAN_W-1:0] SPAN_MAX = (SPAN_BITS >= SPAN_W) ? {SPAN_W{1'b1}}
                                           : SPAN_W'((64'd1 << SPAN_BITS) - 64'd1);

    // control and architectural state
    logic [SR_W-1:0]        sr_reg;
    logic [PHASE_BITS-1:0]  phase_reg, phase_next;
    logic [AGE_W-1:0]       age_reg, age_next;
    logic                   out_valid_reg, out_valid_next;

    // operand registers
    logic [FREQ_W-1:0]        freq_reg;
    logic [RATE_W-1:0]        rate_abs_reg;
    logic                     rate_neg_reg;
    logic [13:0]              dep_abs_reg;
    logic                     dep_neg_reg;
    logic [SPAN_W-1:0]        hold_reg, rise_reg, diff_reg;
    logic                     need_div_reg, phase_go_reg;
    logic [16:0]              grown_reg, u_reg, u2_reg, t_reg, s_reg, x_reg;
    logic [1:0]               quad_reg;
    logic [31:0]              m_reg;
    logic [19:0]              q_reg;
    logic [4:0]               k_reg;
    logic [15:0]              f_reg;
    logic [41:0]              prod_reg;
    logic [FREQ_W-1:0]        out_freq_reg;
    logic                     sat_reg;

    logic [31:0]              mul_a, mul_b;
    logic [63:0]              mul_p;

    logic                     div_done;
    logic [DIV_NUM_W-1:0]     div_num, div_quot;
    logic [DIV_DEN_W-1:0]     div_den;

    logic [SPAN_W-1:0]        hold_cl, rise_cl;
    logic [DEPTH_W-1:0]       dep_mag;
    logic [AGE_W-1:0]         diff_full;
    logic                     bending;
    logic [31:0]              p32;
    logic signed [20:0]       e_val;
    logic signed [6:0]        amt_s;
    logic [51:0]              wide, shifted;

    dvpb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        case (cmd.div_sel)
            DSEL_GROWN:
            begin
                div_num = DIV_NUM_W'({diff_reg, 16'd0});
                div_den = rise_reg;
            end
            DSEL_PHASE:
            begin
                div_num = DIV_NUM_W'(rate_abs_reg) << (PHASE_BITS - 8);
                div_den = DIV_DEN_W'(sr_reg);
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_S1:   begin mul_a = 32'(u_reg);            mul_b = 32'(u_reg);   end
            OP_S2:   begin mul_a = 32'(SIN_C);            mul_b = 32'(u2_reg);  end
            OP_S3:   begin mul_a = 32'(SIN_B - t_reg);    mul_b = 32'(u2_reg);  end
            OP_S4:   begin mul_a = 32'(SIN_A - t_reg);    mul_b = 32'(u_reg);   end
            OP_M1:   begin mul_a = 32'(dep_abs_reg);      mul_b = 32'(grown_reg); end
            OP_M2:   begin mul_a = m_reg;                 mul_b = 32'(s_reg);   end
            OP_M3:   begin mul_a = 32'(m_reg[31:4]);      mul_b = 32'(RECIP_75); end
            OP_X1:   begin mul_a = 32'(EXP_C3);           mul_b = 32'(f_reg);   end
            OP_X2:   begin mul_a = 32'(EXP_C2 + x_reg);   mul_b = 32'(f_reg);   end
            OP_X3:   begin mul_a = 32'(EXP_C1 + x_reg);   mul_b = 32'(f_reg);   end
            OP_X4:   begin mul_a = 32'(freq_reg);         mul_b = 32'({1'b0, Q16_ONE} + 18'(x_reg)); end
            default: begin mul_a = '0;                    mul_b = '0;           end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    always_comb
    begin
        hold_cl   = (hold_samples > SPAN_MAX) ? SPAN_MAX : hold_samples;
        rise_cl   = (rise_samples > SPAN_MAX) ? SPAN_MAX : rise_samples;
        dep_mag   = depth_cents[DEPTH_W-1] ? DEPTH_W'(-depth_cents) : DEPTH_W'(depth_cents);
        bending   = (age_reg >= AGE_W'(hold_reg));
        diff_full = age_reg - AGE_W'(hold_reg);
        p32       = 32'(phase_reg) << (32 - PHASE_BITS);
        e_val     = (dep_neg_reg ^ quad_reg[1]) ? -$signed({1'b0, q_reg})
                                                :  $signed({1'b0, q_reg});
        // 2^k with k in -10..10: left-align then shift right by 26-k
        amt_s     = 7'sd26 - {{2{k_reg[4]}}, k_reg};
        wide      = {prod_reg, 10'd0};
        shifted   = wide >> amt_s[5:0];
    end

    always_comb
    begin
        phase_next     = phase_reg;
        age_next       = age_reg;
        out_valid_next = out_valid_reg;
        if (out_ch.valid && out_ch.ready)
            out_valid_next = 1'b0;
        case (cmd.op)
            OP_LOAD:
            begin
                if (voice_start)
                begin
                    phase_next = '0;
                    age_next   = '0;
                end
            end
            OP_PTAKE:
            begin
                if (rate_neg_reg)
                    phase_next = phase_reg - div_quot[PHASE_BITS-1:0];
                else
                    phase_next = phase_reg + div_quot[PHASE_BITS-1:0];
            end
            OP_OUT:
            begin
                out_valid_next = 1'b1;
                if (age_reg < AGE_W'(hold_reg) + AGE_W'(rise_reg))
                    age_next = age_reg + 1'b1;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sr_reg        <= SR_RESET;
            phase_reg     <= '0;
            age_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_ch.valid)
                sr_reg <= cfg_ch.sample_rate;
            phase_reg     <= phase_next;
            age_reg       <= age_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                freq_reg     <= in_freq;
                rate_abs_reg <= lfo_rate[RATE_W-1] ? RATE_W'(-lfo_rate) : RATE_W'(lfo_rate);
                rate_neg_reg <= lfo_rate[RATE_W-1];
                dep_abs_reg  <= (dep_mag > DEPTH_W'(DEPTH_MAX)) ? DEPTH_MAX : dep_mag[13:0];
                dep_neg_reg  <= depth_cents[DEPTH_W-1];
                hold_reg     <= hold_cl;
                rise_reg     <= rise_cl;
            end
            OP_GSET:
            begin
                diff_reg     <= diff_full[SPAN_W-1:0];
                need_div_reg <= 1'b0;
                phase_go_reg <= bending && (sr_reg != '0);
                if (!bending)
                    grown_reg <= '0;
                else if (rise_reg == '0 || diff_full >= AGE_W'(rise_reg))
                    grown_reg <= Q16_ONE;
                else
                    need_div_reg <= 1'b1;
                quad_reg <= p32[31:30];
                u_reg    <= p32[30] ? Q16_ONE - 17'(p32[29:14]) : 17'(p32[29:14]);
            end
            OP_GTAKE: grown_reg <= div_quot[16:0];
            OP_S1:    u2_reg    <= mul_p[32:16];
            OP_S2:    t_reg     <= mul_p[32:16];
            OP_S3:    t_reg     <= mul_p[32:16];
            OP_S4:    s_reg     <= mul_p[32:16];
            OP_M1:    m_reg     <= mul_p[31:0];
            OP_M2:    m_reg     <= mul_p[47:16];
            OP_M3:    q_reg     <= mul_p[52:33];
            OP_ETAKE:
            begin
                k_reg <= e_val[20:16];
                f_reg <= e_val[15:0];
            end
            OP_X1:    x_reg     <= mul_p[32:16];
            OP_X2:    x_reg     <= mul_p[32:16];
            OP_X3:    x_reg     <= mul_p[32:16];
            OP_X4:    prod_reg  <= mul_p[41:0];
            OP_OUT:
            begin
                sat_reg      <= |shifted[51:FREQ_W];
                out_freq_reg <= (|shifted[51:FREQ_W]) ? OUT_MAX : shifted[FREQ_W-1:0];
            end
            default:
            begin
                sat_reg <= sat_reg;
            end
        endcase
    end

    assign cfg_ch.ready    = 1'b1;
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_freq = out_freq_reg;
    assign out_ch.saturated = sat_reg;

    assign stat.need_div = need_div_reg;
    assign stat.phase_go = phase_go_reg;
    assign stat.div_done = div_done;
    assign stat.out_busy = out_valid_reg && !out_ch.ready;

    `ASSERT_IMPL(a_no_overwrite, cmd.op == OP_OUT, !(out_valid_reg && !out_ch.ready))
    `ASSERT_IMPL(a_grown_cap, cmd.op == OP_M1, grown_reg <= Q16_ONE)

endmodule

@@ rtl/dvpb_ctrl.sv @@
// controller: sequences the datapath micro-operations for one item
// depends on dvpb_pkg and assert_macros.svh
`include "assert_macros.svh"
module dvpb_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  dvpb_pkg::dvpb_stat_t  stat,
    output dvpb_pkg::dvpb_cmd_t   cmd
);
    import dvpb_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_GSET, S_GCHK, S_GWAIT, S_GTAKE,
        S_S1, S_S2, S_S3, S_S4, S_M1, S_M2, S_M3,
        S_ETAKE,
        S_X1, S_X2, S_X3, S_X4,
        S_PCHK, S_PWAIT, S_PTAKE, S_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd.op        = OP_NOP;
        cmd.div_start = 1'b0;
        cmd.div_sel   = DSEL_GROWN;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_GSET;
                end
            end
            S_GSET:  begin cmd.op = OP_GSET; state_next = S_GCHK; end
            S_GCHK:
            begin
                if (stat.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_GWAIT;
                end
                else
                    state_next = S_S1;
            end
            S_GWAIT: if (stat.div_done) state_next = S_GTAKE;
            S_GTAKE: begin cmd.op = OP_GTAKE; state_next = S_S1; end
            S_S1:    begin cmd.op = OP_S1; state_next = S_S2; end
            S_S2:    begin cmd.op = OP_S2; state_next = S_S3; end
            S_S3:    begin cmd.op = OP_S3; state_next = S_S4; end
            S_S4:    begin cmd.op = OP_S4; state_next = S_M1; end
            S_M1:    begin cmd.op = OP_M1; state_next = S_M2; end
            S_M2:    begin cmd.op = OP_M2; state_next = S_M3; end
            // divide by 1200 through the reciprocal product
            S_M3:    begin cmd.op = OP_M3; state_next = S_ETAKE; end
            S_ETAKE: begin cmd.op = OP_ETAKE; state_next = S_X1; end
            S_X1:    begin cmd.op = OP_X1; state_next = S_X2; end
            S_X2:    begin cmd.op = OP_X2; state_next = S_X3; end
            S_X3:    begin cmd.op = OP_X3; state_next = S_X4; end
            S_X4:    begin cmd.op = OP_X4; state_next = S_PCHK; end
            S_PCHK:
            begin
                cmd.div_sel = DSEL_PHASE;
                if (stat.phase_go)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_PWAIT;
                end
                else
                    state_next = S_OUT;
            end
            S_PWAIT:
            begin
                cmd.div_sel = DSEL_PHASE;
                if (stat.div_done)
                    state_next = S_PTAKE;
            end
            S_PTAKE: begin cmd.op = OP_PTAKE; state_next = S_OUT; end
            S_OUT:
            begin
                // wait for room in the output register
                if (!stat.out_busy)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);

    `ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)
    `ASSERT_IMPL(a_div_wait, state_reg == S_GWAIT || state_reg == S_PWAIT, cmd.op == OP_NOP)

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for delayed_vibrato_pitch_bend_top: directed table, then random voices
// depends on dvpb_pkg, the channel interfaces in dvpb_ifs.sv and the rtl of the block
module testbench;
    import dvpb_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 3000000;
    localparam int unsigned SETTLE      = 250;
    localparam int unsigned NUM_RANDOM  = 1880;

    typedef struct packed {
        logic               voice_start;
        logic [23:0]        in_freq;
        logic signed [15:0] lfo_rate;
        logic signed [14:0] depth_cents;
        logic [19:0]        hold_samples;
        logic [19:0]        rise_samples;
    } bend_item_t;

    typedef struct packed {
        logic [23:0] out_freq;
        logic        saturated;
    } bend_result_t;

    typedef struct packed {
        bend_item_t   item;
        logic         typed;
        bend_result_t want;
    } table_row_t;

    localparam int unsigned NUM_ROWS = 20;
    localparam table_row_t STIM_TABLE [NUM_ROWS] = '{
        // depth zero, phase zero or frequency zero pass the frequency through unchanged; then extreme depths and rates
        '{'{1'b1, 24'h000100, 16'sd0, 15'sd0, 20'd0, 20'd0}, 1'b1, '{24'h000100, 1'b0}},
        '{'{1'b0, 24'hFFFFFF, 16'sh7FFF, 15'sd0, 20'd0, 20'd0}, 1'b1, '{24'hFFFFFF, 1'b0}},
        '{'{1'b0, 24'h000000, -16'sd32768, 15'sd12000, 20'd0, 20'd0}, 1'b1, '{24'h0, 1'b0}},
        '{'{1'b1, 24'h123456, 16'sd256, 15'sd12000, 20'd0, 20'd0}, 1'b1, '{24'h123456, 1'b0}},
        '{'{1'b0, 24'h123456, 16'sh7FFF, 15'sd12000, 20'd0, 20'd0}, 1'b0, '0},
        '{'{1'b0, 24'hFFFFFF, 16'sh7FFF, 15'sd12000, 20'd0, 20'd0}, 1'b0, '0},
        '{'{1'b0, 24'hFFFFFF, 16'sh7FFF, 15'sd16383, 20'd0, 20'd0}, 1'b0, '0},
        '{'{1'b0, 24'h800000, -16'sd32768, -15'sd16384, 20'd0, 20'd0}, 1'b0, '0},
        '{'{1'b0, 24'h000001, -16'sd1, -15'sd12000, 20'd0, 20'd0}, 1'b0, '0},
        // hold then a ramp of four samples
        '{'{1'b1, 24'h01B800, 16'sd1536, 15'sd600, 20'd3, 20'd4}, 1'b0, '0},
        '{'{1'b0, 24'h01B800, 16'sd1536, 15'sd600, 20'd3, 20'd4}, 1'b0, '0},
        '{'{1'b0, 24'h01B800, 16'sd1536, 15'sd600, 20'd3, 20'd4}, 1'b0, '0},
        '{'{1'b0, 24'h01B800, 16'sd1536, 15'sd600, 20'd3, 20'd4}, 1'b0, '0},
        '{'{1'b0, 24'h01B800, 16'sd1536, 15'sd600, 20'd3, 20'd4}, 1'b0, '0},
        '{'{1'b0, 24'h01B800, 16'sd1536, 15'sd600, 20'd3, 20'd4}, 1'b0, '0},
        // hold and rise lowered below the age
        '{'{1'b0, 24'h01B800, 16'sd1536, 15'sd600, 20'd1, 20'd1}, 1'b0, '0},
        '{'{1'b0, 24'h01B800, 16'sd1536, 15'sd600, 20'd0, 20'd1}, 1'b0, '0},
        '{'{1'b1, 24'h01B800, 16'sd1536, 15'sd600, 20'hFFFFF, 20'hFFFFF}, 1'b1,
          '{24'h01B800, 1'b0}},
        '{'{1'b1, 24'h01B800, 16'sd1536, 15'sd600, 20'd0, 20'd1}, 1'b0, '0},
        '{'{1'b0, 24'h01B800, 16'sd1536, 15'sd600, 20'd0, 20'd1}, 1'b0, '0}
    };

    logic clk;
    logic rst_n;

    dvpb_in_if  in_ch ();
    dvpb_out_if out_ch ();
    dvpb_cfg_if cfg_ch ();

    delayed_vibrato_pitch_bend_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    // model state
    logic [17:0]    rate_reg;
    logic [31:0]    lfo_phase;
    logic [21:0]    voice_age;

    bend_result_t   pending_q[$];
    int unsigned    errors;
    int unsigned    results_seen;
    int unsigned    saturations;
    int unsigned    cycles;
    bit             idle_on;

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycles, pending_q.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic report(input string what, input logic [23:0] got, input logic [23:0] want);
        errors++;
        $display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
    endtask

    function automatic longint sine_q16(input logic [31:0] ph);
        longint unsigned u;
        longint unsigned u2;
        longint unsigned t;
        longint unsigned s;
        logic [1:0]      quad;
        quad = ph[31:30];
        u = ph[29:14];
        if (quad[0])
            u = 65536 - u;
        u2 = (u * u) >> 16;
        t = (longint'(SIN_C) * u2) >> 16;
        t = ((longint'(SIN_B) - t) * u2) >> 16;
        t = longint'(SIN_A) - t;
        s = (t * u) >> 16;
        return quad[1] ? -longint'(s) : longint'(s);
    endfunction

    // bends one sample and advances phase and age
    function automatic bend_result_t bend_sample(input bend_item_t it);
        longint          depth;
        longint          hold;
        longint          rise;
        longint          grown;
        longint          s;
        longint          e;
        longint          k;
        longint unsigned mag;
        longint unsigned f;
        longint unsigned t;
        longint unsigned prod;
        longint unsigned val;
        longint unsigned inc;
        bit              bending;
        bend_result_t    r;
        depth = it.depth_cents;
        hold = it.hold_samples;
        rise = it.rise_samples;
        if (depth > 12000)
            depth = 12000;
        if (depth < -12000)
            depth = -12000;
        if (it.voice_start)
        begin
            lfo_phase = '0;
            voice_age = '0;
        end
        bending = longint'(voice_age) >= hold;
        if (!bending)
            grown = 0;
        else if (rise >= 1)
        begin
            grown = ((longint'(voice_age) - hold) << 16) / rise;
            if (grown > 65536)
                grown = 65536;
        end
        else
            grown = 65536;
        s = sine_q16(lfo_phase);
        mag = (depth < 0 ? -depth : depth) * grown;
        mag = (mag * (s < 0 ? -s : s)) >> 16;
        mag = mag / 1200;
        e = ((depth < 0) != (s < 0)) ? -longint'(mag) : longint'(mag);
        if (e >= 0)
            k = e >>> 16;
        else
            k = -((-e + 65535) >>> 16);
        f = e - k * 65536;
        t = (longint'(EXP_C3) * f) >> 16;
        t = ((longint'(EXP_C2) + t) * f) >> 16;
        t = ((longint'(EXP_C1) + t) * f) >> 16;
        prod = longint'(it.in_freq) * (65536 + t);
        if (k >= 0)
            val = (prod << k) >> 16;
        else
            val = prod >> (16 - k);
        r.saturated = val > 64'hFFFFFF;
        r.out_freq = r.saturated ? OUT_MAX : val[23:0];
        if (longint'(voice_age) < hold + rise)
            voice_age = voice_age + 22'd1;
        if (bending && rate_reg != 0)
        begin
            inc = (longint'(it.lfo_rate < 0 ? -longint'(it.lfo_rate) : longint'(it.lfo_rate))
                   << 24) / rate_reg;
            if (it.lfo_rate < 0)
                lfo_phase = lfo_phase - inc[31:0];
            else
                lfo_phase = lfo_phase + inc[31:0];
        end
        return r;
    endfunction

    // result side: ready stalls in bursts while idle_on is set, beats checked in order
    initial
    begin : result_side
        int stall;
        bend_result_t want;
        stall = 0;
        out_ch.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            @(negedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                results_seen++;
                if (pending_q.size() == 0)
                    report("unexpected beat out_freq", out_ch.out_freq, 24'h0);
                else
                begin
                    want = pending_q.pop_front();
                    if (out_ch.out_freq !== want.out_freq)
                        report("out_freq", out_ch.out_freq, want.out_freq);
                    if (out_ch.saturated !== want.saturated)
                        report("saturated", 24'(out_ch.saturated), 24'(want.saturated));
                    if (want.saturated)
                        saturations++;
                end
            end
            @(posedge clk);
            if (stall > 0)
                stall--;
            else if (idle_on && $urandom_range(0, 5) == 0)
                stall = $urandom_range(1, 5);
            out_ch.ready <= (stall == 0);
        end
    end

    // call at a rising edge; returns at the edge where the beat is taken, or after a random idle gap
    task automatic send_item(input bend_item_t it, input bit typed, input bend_result_t want);
        bit taken;
        bend_result_t got;
        in_ch.valid        <= 1'b1;
        in_ch.voice_start  <= it.voice_start;
        in_ch.in_freq      <= it.in_freq;
        in_ch.lfo_rate     <= it.lfo_rate;
        in_ch.depth_cents  <= it.depth_cents;
        in_ch.hold_samples <= it.hold_samples;
        in_ch.rise_samples <= it.rise_samples;
        do
        begin
            @(negedge clk);
            taken = in_ch.ready;
            @(posedge clk);
        end
        while (!taken);
        got = bend_sample(it);
        if (typed && got !== want)
            report("typed row vs predictor", got.out_freq, want.out_freq);
        pending_q.push_back(typed ? want : got);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic drain_and_settle();
        in_ch.valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_rate(input logic [17:0] value);
        bit taken;
        cfg_ch.valid       <= 1'b1;
        cfg_ch.sample_rate <= value;
        do
        begin
            @(negedge clk);
            taken = cfg_ch.ready;
            @(posedge clk);
        end
        while (!taken);
        cfg_ch.valid <= 1'b0;
        rate_reg = value;
        @(posedge clk);
    endtask

    function automatic bend_item_t random_item();
        bend_item_t it;
        it.voice_start  = 1'($urandom_range(0, 1));
        it.in_freq      = 24'($urandom);
        it.lfo_rate     = 16'($urandom);
        it.depth_cents  = 15'($urandom);
        it.hold_samples = 20'($urandom);
        it.rise_samples = 20'($urandom);
        return it;
    endfunction

    // one voice: start, then samples with random frequency; settings fixed but for hold and rise halved now and then
    task automatic play_voice(inout int unsigned sent);
        bend_item_t   it;
        bend_result_t none;
        int           len;
        none = '0;
        it = random_item();
        it.voice_start = 1'b1;
        if ($urandom_range(0, 9) != 0)
        begin
            it.hold_samples = 20'($urandom_range(0, 30));
            it.rise_samples = 20'($urandom_range(0, 30));
            if ($urandom_range(0, 3) == 0)
                it.rise_samples = '0;
        end
        if ($urandom_range(0, 9) != 0)
            it.depth_cents = 15'($urandom_range(0, 24000) - 12000);
        len = $urandom_range(5, 40);
        for (int i = 0; i < len; i++)
        begin
            send_item(it, 1'b0, none);
            sent++;
            it.voice_start = 1'b0;
            it.in_freq = 24'($urandom);
            if ($urandom_range(0, 3) == 0)
                it.in_freq = 24'($urandom_range(0, 24'h0FFFFF));
            // settings lowered mid voice now and then
            if ($urandom_range(0, 29) == 0)
            begin
                it.hold_samples = it.hold_samples >> 1;
                it.rise_samples = it.rise_samples >> 1;
            end
        end
    endtask

    initial
    begin : stimulus
        int unsigned  sent;
        bend_result_t none;
        logic [17:0]  rates [5];
        none = '0;
        sent = 0;
        idle_on = 1'b1;
        rate_reg = SR_RESET;
        lfo_phase = '0;
        voice_age = '0;
        rates = '{18'd8000, 18'd192000, 18'h3FFFF, 18'd0, 18'd44100};
        in_ch.valid = 1'b0;
        in_ch.voice_start = 1'b0;
        in_ch.in_freq = '0;
        in_ch.lfo_rate = '0;
        in_ch.depth_cents = '0;
        in_ch.hold_samples = '0;
        in_ch.rise_samples = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.sample_rate = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset value of the rate register first
        for (int r = 0; r < NUM_ROWS; r++)
            send_item(STIM_TABLE[r].item, STIM_TABLE[r].typed, STIM_TABLE[r].want);
        drain_and_settle();

        for (int ph = 0; ph < 5; ph++)
        begin
            write_rate(rates[ph]);
            if (ph == 4)
                idle_on = 1'b0;
            while (sent < (ph + 1) * NUM_RANDOM / 5)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_item(random_item(), 1'b0, none);
                    sent++;
                end
                else
                    play_voice(sent);
            end
            drain_and_settle();
        end

        $display("covered %0d table rows and %0d random samples over 6 sample rates",
                 NUM_ROWS, sent);
        $display("%0d results checked, %0d saturated, %0d mismatches",
                 results_seen, saturations, errors);
        if (errors == 0 && pending_q.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/dvpb_pkg.sv
rtl/dvpb_ifs.sv
rtl/dvpb_div.sv
rtl/dvpb_datapath.sv
rtl/dvpb_ctrl.sv
rtl/delayed_vibrato_pitch_bend_top.sv
tb/testbench.sv
